// File: rtl/kuw_pkg.sv
// ---------------------------------------------------------------------------
// kuw_pkg
// shared types and constants of the keyed unlock watchdog: command and
// response words, opcodes, lock indexes, lock stages and unlock keys
// ---------------------------------------------------------------------------
package kuw_pkg;

	// opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// lock index, reg_select[2:1]
	localparam logic [1:0] LK_KICK     = 2'd0;
	localparam logic [1:0] LK_RELOAD   = 2'd1;
	localparam logic [1:0] LK_ENABLE   = 2'd2;
	localparam logic [1:0] LK_PRESCALE = 2'd3;

	// lock stages
	localparam logic [1:0] STG_LOCKED = 2'd0;
	localparam logic [1:0] STG_FIRST  = 2'd1;
	localparam logic [1:0] STG_SECOND = 2'd2;
	localparam logic [1:0] STG_OPEN   = 2'd3;

	// keys
	localparam logic [15:0] KEY_KICK_1     = 16'h5555;
	localparam logic [15:0] KEY_KICK_2     = 16'haaaa;
	localparam logic [15:0] KEY_PRESCALE_1 = 16'h5a5a;
	localparam logic [15:0] KEY_PRESCALE_2 = 16'ha5a5;
	localparam logic [15:0] KEY_RELOAD_1   = 16'h6666;
	localparam logic [15:0] KEY_RELOAD_2   = 16'hbbbb;
	localparam logic [15:0] KEY_ENABLE_1   = 16'h7777;
	localparam logic [15:0] KEY_ENABLE_2   = 16'hcccc;
	localparam logic [15:0] KEY_ENABLE_3   = 16'hdddd;

	// reset value of reload and count registers
	localparam logic [15:0] COUNT_RESET = 16'hffff;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  reg_select;
		logic [15:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        expired;
		logic        running;
	} rsp_t;

	function automatic logic [15:0] first_key(input logic [1:0] idx);
		logic [15:0] k;
		unique case (idx)
			LK_KICK:     k = KEY_KICK_1;
			LK_RELOAD:   k = KEY_RELOAD_1;
			LK_ENABLE:   k = KEY_ENABLE_1;
			LK_PRESCALE: k = KEY_PRESCALE_1;
			default:     k = KEY_KICK_1;
		endcase
		return k;
	endfunction

	function automatic logic [15:0] second_key(input logic [1:0] idx);
		logic [15:0] k;
		unique case (idx)
			LK_KICK:     k = KEY_KICK_2;
			LK_RELOAD:   k = KEY_RELOAD_2;
			LK_ENABLE:   k = KEY_ENABLE_2;
			LK_PRESCALE: k = KEY_PRESCALE_2;
			default:     k = KEY_KICK_2;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/keyed_unlock_watchdog.sv
// ---------------------------------------------------------------------------
// keyed_unlock_watchdog
// watchdog timer with four key-protected control registers (kick, reload,
// enable, prescale), one command word in and one response word out
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  cmd     | in        | cmd_valid/cmd_stall | cmd_t: opcode, reg_select, write_data
//  rsp     | out       | rsp_valid/rsp_stall | rsp_t: read_data, expired, running
//
//  one command per cycle while the response is not stalled; a command goes from
//  the command register, then through execute into the response register
//  the execute step is a single pass: key compare, prescale/count decrement
//  and reload, read mux
//  reset clears all lock stages, disables the watchdog and sets reloads and
//  counts to 0xffff; no clearing pass
//  a stalled response holds the pipe; cmd_stall rises only when the command
//  register is full and cannot move on
// ---------------------------------------------------------------------------
module keyed_unlock_watchdog import kuw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// command register
	logic cmd_valid_s1;
	cmd_t cmd_s1;

	// response register
	logic rsp_valid_s2;
	rsp_t rsp_s2;

	// execute result of the command in stage one
	rsp_t res;

	logic adv_s2;   // stage one moves into the response register
	logic take;     // command accepted

	// response register frees when empty or when its word is taken
	assign adv_s2    = cmd_valid_s1 && (!rsp_valid_s2 || !rsp_stall);
	assign cmd_stall = cmd_valid_s1 && !adv_s2;
	assign take      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (take) begin
			cmd_valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
	end

	// state commits exactly when the command's response is written
	kuw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s2),
		.cmd    (cmd_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			rsp_valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			rsp_s2 <= res;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	// stall only with a full command register
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> cmd_valid_s1 && rsp_valid_s2 && rsp_stall)
		else $error("cmd stalled without a blocked pipe");

	// expiry happens only on an enabled tick
	a_exp_running: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.expired |-> rsp.running)
		else $error("expired while not running");

	// a command in stage one that is not stalled reaches the response register
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_s1 && !cmd_stall |=> rsp_valid_s2)
		else $error("command lost between stages");

endmodule

// File: rtl/kuw_core.sv
// ---------------------------------------------------------------------------
// kuw_core
// watchdog state and the one-pass execute logic: lock stages, protected
// registers, prescaler and main count; state commits when step is high
// ---------------------------------------------------------------------------
module kuw_core import kuw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  cmd_t cmd,
	output rsp_t res
);

	logic [1:0]  lock_stage_q [4];
	logic [15:0] prescale_reload_q;
	logic [15:0] count_reload_q;
	logic        enable_q;
	logic [15:0] prescale_count_q;
	logic [15:0] main_count_q;

	logic [1:0]  lock_stage_d [4];
	logic [15:0] prescale_reload_d;
	logic [15:0] count_reload_d;
	logic        enable_d;
	logic [15:0] prescale_count_d;
	logic [15:0] main_count_d;

	logic [1:0]  idx;
	logic        is_lock;
	logic [1:0]  cur_stage;

	assign idx       = cmd.reg_select[2:1];
	assign is_lock   = ~cmd.reg_select[0];
	assign cur_stage = lock_stage_q[idx];

	always_comb begin
		lock_stage_d      = lock_stage_q;
		prescale_reload_d = prescale_reload_q;
		count_reload_d    = count_reload_q;
		enable_d          = enable_q;
		prescale_count_d  = prescale_count_q;
		main_count_d      = main_count_q;
		res.read_data     = '0;
		res.expired       = 1'b0;
		unique case (cmd.opcode)
			OP_TICK: begin
				if (enable_q) begin
					if (prescale_count_q > 16'd1) begin
						prescale_count_d = prescale_count_q - 16'd1;
					end else begin
						prescale_count_d = prescale_reload_q;
						if (main_count_q > 16'd1) begin
							main_count_d = main_count_q - 16'd1;
						end else begin
							main_count_d = count_reload_q;
							res.expired  = 1'b1;
						end
					end
				end
			end
			OP_WRITE: begin
				if (is_lock) begin
					// first key restarts the sequence from any stage
					priority if (cmd.write_data == first_key(idx)) begin
						lock_stage_d[idx] = STG_FIRST;
					end else if (cur_stage == STG_FIRST &&
					             cmd.write_data == second_key(idx)) begin
						lock_stage_d[idx] = (idx == LK_ENABLE) ? STG_SECOND : STG_OPEN;
					end else if (idx == LK_ENABLE && cur_stage == STG_SECOND &&
					             cmd.write_data == KEY_ENABLE_3) begin
						lock_stage_d[idx] = STG_OPEN;
					end else begin
						lock_stage_d[idx] = STG_LOCKED;
					end
				end else if (cur_stage == STG_OPEN) begin
					lock_stage_d[idx] = STG_LOCKED;
					unique case (idx)
						LK_KICK: begin
							main_count_d     = count_reload_q;
							prescale_count_d = prescale_reload_q;
						end
						LK_RELOAD:   count_reload_d    = cmd.write_data;
						LK_ENABLE:   enable_d          = cmd.write_data[0];
						LK_PRESCALE: prescale_reload_d = cmd.write_data;
						default: ;
					endcase
				end
			end
			OP_READ: begin
				if (is_lock) begin
					res.read_data = {14'd0, cur_stage};
				end else begin
					unique case (idx)
						LK_KICK:     res.read_data = '0;
						LK_RELOAD:   res.read_data = count_reload_q;
						LK_ENABLE:   res.read_data = {15'd0, enable_q};
						LK_PRESCALE: res.read_data = prescale_reload_q;
						default:     res.read_data = '0;
					endcase
				end
			end
			default: ;
		endcase
		res.running = enable_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) lock_stage_q[i] <= STG_LOCKED;
			prescale_reload_q <= COUNT_RESET;
			count_reload_q    <= COUNT_RESET;
			enable_q          <= 1'b0;
			prescale_count_q  <= COUNT_RESET;
			main_count_q      <= COUNT_RESET;
		end else if (step) begin
			lock_stage_q      <= lock_stage_d;
			prescale_reload_q <= prescale_reload_d;
			count_reload_q    <= count_reload_d;
			enable_q          <= enable_d;
			prescale_count_q  <= prescale_count_d;
			main_count_q      <= main_count_d;
		end
	end

	// only the enable lock has a middle stage
	a_no_mid_stage: assert property (@(posedge clk) disable iff (!arst_n)
		lock_stage_q[LK_KICK] != STG_SECOND && lock_stage_q[LK_RELOAD] != STG_SECOND &&
		lock_stage_q[LK_PRESCALE] != STG_SECOND)
		else $error("non-enable lock reached the middle stage");

	// a protected write only lands through an open lock, which then relocks
	a_relock: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd.opcode == OP_WRITE && !is_lock && cur_stage == STG_OPEN
		|=> lock_stage_q[$past(idx)] == STG_LOCKED)
		else $error("lock not cleared after protected write");

	// counts only move while enabled or on a kick
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd.opcode == OP_TICK && !enable_q |=> $stable(main_count_q))
		else $error("main count moved while disabled");

endmodule
